FILE: sv/rpe_pkg.sv
// ---------------------------------------------------------------------------
// rpe_pkg
// shared constants, types and rounding for the rotary position embedding
// ---------------------------------------------------------------------------
package rpe_pkg;

   localparam int MAX_POSITIONS = 1024;
   localparam int MAX_HALF      = 64;
   localparam int DATA_WIDTH    = 16;

   localparam int ROW_BITS   = $clog2(MAX_POSITIONS);
   localparam int COL_BITS   = $clog2(MAX_HALF);
   localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
   localparam int TABLE_DEPTH = MAX_POSITIONS * MAX_HALF;

   localparam int HALF_BITS = 7;
   localparam int ROWS_BITS = 11;
   localparam int POS_BITS  = 11;
   localparam int CSR_BITS  = 11;
   localparam int COEF_BITS = 16;

   localparam int PROD_BITS = DATA_WIDTH + COEF_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;
   localparam int QUOT_BITS = SUM_BITS - 15;

   localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(64);
   localparam logic [ROWS_BITS-1:0] ROWS_RESET = ROWS_BITS'(1024);

   typedef enum logic {
      CSR_HALF_WIDTH = 1'b0,
      CSR_TABLE_ROWS = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD   = 1'b0,
      KIND_ROTATE = 1'b1
   } kind_type;

   typedef struct packed {
      logic                       en;
      logic                       we;
      logic [ADDR_BITS-1:0]       addr;
      logic [2*COEF_BITS-1:0]     wdata;
   } ram_req_type;

   typedef struct packed {
      logic                          valid;
      logic                          oor;
      logic signed [DATA_WIDTH-1:0]  x_first;
      logic signed [DATA_WIDTH-1:0]  x_second;
   } stage_type;

   function automatic logic signed [DATA_WIDTH-1:0] round_sat(
      input logic signed [SUM_BITS-1:0] sum
   );
      logic signed [SUM_BITS-1:0]  v;
      logic signed [QUOT_BITS-1:0] q;
      logic signed [QUOT_BITS-1:0] hi;
      logic signed [QUOT_BITS-1:0] lo;
      v  = sum + SUM_BITS'(16384);
      q  = QUOT_BITS'(v >>> 15);
      hi = QUOT_BITS'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
      lo = -hi - QUOT_BITS'(1);
      if (q > hi) begin
         round_sat = DATA_WIDTH'(hi);
      end else if (q < lo) begin
         round_sat = DATA_WIDTH'(lo);
      end else begin
         round_sat = DATA_WIDTH'(q);
      end
   endfunction

endpackage

FILE: sv/rotary_position_embedding.sv
// ---------------------------------------------------------------------------
// rotary_position_embedding
// cos/sin table and rotate-half pair rotation in Q1.15 fixed point
//
// channel  dir  handshake           payload
// req      in   tvalid/tready       tdata fields, tuser = kind
// rsp      out  tvalid/tready       tdata y pair, tuser = out_of_range
// csr      in   csr_wen             csr_index, csr_wdata
//
// one item per cycle while the output buffer has room
// stages: input register, table ram read, products, round and saturate
// the table ram port takes one load write or one rotate read per cycle
// reset clears valid bits, sets csr defaults; data and table stay undefined
// a stall holds the whole pipeline; a two entry output buffer parts the sides
// ---------------------------------------------------------------------------
module rotary_position_embedding (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // load_row[9:0] column[15:10] cos_value[31:16] sin_value[47:32]
   // position[58:48] x_first[74:59] x_second[90:75] zero[95:91]
   input  logic [95:0]                          req_tdata,
   // kind[0]
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // y_first[15:0] y_second[31:16]
   output logic [2*rpe_pkg::DATA_WIDTH-1:0]     rsp_tdata,
   // out_of_range[0]
   output logic                                 rsp_tuser,
   input  logic                                 csr_wen,
   input  logic                                 csr_index,
   input  logic [rpe_pkg::CSR_BITS-1:0]         csr_wdata
);
   import rpe_pkg::*;

   logic [HALF_BITS-1:0]         half_width_ff, half_width_in;
   logic [ROWS_BITS-1:0]         table_rows_ff, table_rows_in;

   logic                         advance;
   logic                         accept;
   ram_req_type                  ram_req;
   stage_type                    stage;
   logic [2*COEF_BITS-1:0]       coef;
   logic                         res_valid;
   logic signed [DATA_WIDTH-1:0] res_y_first;
   logic signed [DATA_WIDTH-1:0] res_y_second;
   logic                         res_oor;
   logic                         buf_ready;

   always_comb begin
      half_width_in = half_width_ff;
      table_rows_in = table_rows_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_HALF_WIDTH: half_width_in = csr_wdata[HALF_BITS-1:0];
            CSR_TABLE_ROWS: table_rows_in = csr_wdata[ROWS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= HALF_RESET;
         table_rows_ff <= ROWS_RESET;
      end else begin
         half_width_ff <= half_width_in;
         table_rows_ff <= table_rows_in;
      end
   end

   assign advance    = buf_ready;
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;

   rpe_addr u_addr (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .accept     (accept),
      .kind       (req_tuser),
      .load_row   (req_tdata[9:0]),
      .column     (req_tdata[15:10]),
      .cos_value  (req_tdata[31:16]),
      .sin_value  (req_tdata[47:32]),
      .position   (signed'(req_tdata[58:48])),
      .x_first    (signed'(req_tdata[74:59])),
      .x_second   (signed'(req_tdata[90:75])),
      .half_width (half_width_ff),
      .table_rows (table_rows_ff),
      .ram_req    (ram_req),
      .stage      (stage)
   );

   rpe_ram #(
      .WIDTH (2*COEF_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .en    (ram_req.en),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (coef)
   );

   rpe_rotate u_rotate (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .stage        (stage),
      .coef         (coef),
      .res_valid    (res_valid),
      .res_y_first  (res_y_first),
      .res_y_second (res_y_second),
      .res_oor      (res_oor)
   );

   rpe_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (buf_ready),
      .in_data   ({res_y_second, res_y_first}),
      .in_flag   (res_oor),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_flag  (rsp_tuser)
   );

`ifndef ASSERT_OFF
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("out of range item carries nonzero data");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled while output is empty");

   a_csr_half: assert property (@(posedge clock) disable iff (reset)
      csr_wen && csr_index == CSR_HALF_WIDTH
      |=> half_width_ff == $past(csr_wdata[HALF_BITS-1:0]))
      else $error("half width write lost");

   a_ram_one_op: assert property (@(posedge clock) disable iff (reset)
      ram_req.en |-> advance)
      else $error("table access while pipeline stalled");
`endif

endmodule

FILE: sv/rpe_ram.sv
// ---------------------------------------------------------------------------
// rpe_ram
// generic single port ram with registered read
// ---------------------------------------------------------------------------
module rpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/rpe_addr.sv
// ---------------------------------------------------------------------------
// rpe_addr
// input register, position wrap, range check and table access
// ---------------------------------------------------------------------------
module rpe_addr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  accept,
   input  logic                                  kind,
   input  logic [rpe_pkg::ROW_BITS-1:0]          load_row,
   input  logic [rpe_pkg::COL_BITS-1:0]          column,
   input  logic [rpe_pkg::COEF_BITS-1:0]         cos_value,
   input  logic [rpe_pkg::COEF_BITS-1:0]         sin_value,
   input  logic signed [rpe_pkg::POS_BITS-1:0]   position,
   input  logic signed [rpe_pkg::DATA_WIDTH-1:0] x_first,
   input  logic signed [rpe_pkg::DATA_WIDTH-1:0] x_second,
   input  logic [rpe_pkg::HALF_BITS-1:0]         half_width,
   input  logic [rpe_pkg::ROWS_BITS-1:0]         table_rows,
   output rpe_pkg::ram_req_type                  ram_req,
   output rpe_pkg::stage_type                    stage
);
   import rpe_pkg::*;

   logic                         valid_ff, valid_in;
   logic                         kind_ff;
   logic [ROW_BITS-1:0]          row_ff;
   logic [COL_BITS-1:0]          col_ff;
   logic [COEF_BITS-1:0]         cos_ff;
   logic [COEF_BITS-1:0]         sin_ff;
   logic signed [POS_BITS-1:0]   pos_ff;
   logic signed [DATA_WIDTH-1:0] x1_ff;
   logic signed [DATA_WIDTH-1:0] x2_ff;
   stage_type                    stage_ff, stage_in;

   logic signed [POS_BITS:0]     wpos;
   logic                         oor;

   assign valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && accept) begin
         kind_ff <= kind;
         row_ff  <= load_row;
         col_ff  <= column;
         cos_ff  <= cos_value;
         sin_ff  <= sin_value;
         pos_ff  <= position;
         x1_ff   <= x_first;
         x2_ff   <= x_second;
      end
   end

   // negative position wraps once by the row count
   always_comb begin
      wpos = (POS_BITS+1)'(pos_ff);
      if (pos_ff < 0) begin
         wpos = (POS_BITS+1)'(pos_ff) + signed'({1'b0, table_rows});
      end
      oor = wpos[POS_BITS]
         || (wpos[POS_BITS-1:0] >= table_rows)
         || (wpos[POS_BITS-1:0] >= POS_BITS'(MAX_POSITIONS))
         || (HALF_BITS'(col_ff) >= half_width)
         || (HALF_BITS'(col_ff) >= HALF_BITS'(MAX_HALF));
   end

   always_comb begin
      ram_req.en    = advance && valid_ff;
      ram_req.we    = (kind_ff == KIND_LOAD);
      ram_req.wdata = {sin_ff, cos_ff};
      if (kind_ff == KIND_LOAD) begin
         ram_req.addr = {row_ff, col_ff};
      end else begin
         ram_req.addr = {wpos[ROW_BITS-1:0], col_ff};
      end
   end

   always_comb begin
      stage_in.valid    = valid_ff && (kind_ff == KIND_ROTATE);
      stage_in.oor      = oor;
      stage_in.x_first  = x1_ff;
      stage_in.x_second = x2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff.oor      <= stage_in.oor;
         stage_ff.x_first  <= stage_in.x_first;
         stage_ff.x_second <= stage_in.x_second;
      end
   end

   assign stage = stage_ff;

endmodule

FILE: sv/rpe_rotate.sv
// ---------------------------------------------------------------------------
// rpe_rotate
// product stage followed by sum, rounding and saturation
// ---------------------------------------------------------------------------
module rpe_rotate (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  rpe_pkg::stage_type                    stage,
   input  logic [2*rpe_pkg::COEF_BITS-1:0]       coef,
   output logic                                  res_valid,
   output logic signed [rpe_pkg::DATA_WIDTH-1:0] res_y_first,
   output logic signed [rpe_pkg::DATA_WIDTH-1:0] res_y_second,
   output logic                                  res_oor
);
   import rpe_pkg::*;

   logic signed [COEF_BITS-1:0] c_val;
   logic signed [COEF_BITS-1:0] s_val;

   logic                        valid_ff;
   logic                        oor_ff;
   logic signed [PROD_BITS-1:0] x1c_ff, x1c_in;
   logic signed [PROD_BITS-1:0] x2s_ff, x2s_in;
   logic signed [PROD_BITS-1:0] x1s_ff, x1s_in;
   logic signed [PROD_BITS-1:0] x2c_ff, x2c_in;

   logic signed [SUM_BITS-1:0]  sum_first;
   logic signed [SUM_BITS-1:0]  sum_second;

   assign c_val = signed'(coef[COEF_BITS-1:0]);
   assign s_val = signed'(coef[2*COEF_BITS-1:COEF_BITS]);

   assign x1c_in = stage.x_first * c_val;
   assign x2s_in = stage.x_second * s_val;
   assign x1s_in = stage.x_first * s_val;
   assign x2c_in = stage.x_second * c_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         oor_ff <= stage.oor;
         x1c_ff <= x1c_in;
         x2s_ff <= x2s_in;
         x1s_ff <= x1s_in;
         x2c_ff <= x2c_in;
      end
   end

   assign sum_first  = SUM_BITS'(x1c_ff) - SUM_BITS'(x2s_ff);
   assign sum_second = SUM_BITS'(x1s_ff) + SUM_BITS'(x2c_ff);

   always_comb begin
      res_valid = valid_ff;
      res_oor   = oor_ff;
      if (oor_ff) begin
         res_y_first  = '0;
         res_y_second = '0;
      end else begin
         res_y_first  = round_sat(sum_first);
         res_y_second = round_sat(sum_second);
      end
   end

endmodule

FILE: sv/rpe_out_buf.sv
// ---------------------------------------------------------------------------
// rpe_out_buf
// two entry output buffer with a registered ready toward the pipeline
// ---------------------------------------------------------------------------
module rpe_out_buf (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [2*rpe_pkg::DATA_WIDTH-1:0]      in_data,
   input  logic                                  in_flag,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [2*rpe_pkg::DATA_WIDTH-1:0]      out_data,
   output logic                                  out_flag
);
   import rpe_pkg::*;

   logic                        main_valid_ff, main_valid_in;
   logic [2*DATA_WIDTH-1:0]     main_data_ff,  main_data_in;
   logic                        main_flag_ff,  main_flag_in;
   logic                        spare_valid_ff, spare_valid_in;
   logic [2*DATA_WIDTH-1:0]     spare_data_ff,  spare_data_in;
   logic                        spare_flag_ff,  spare_flag_in;
   logic                        push;

   assign in_ready = !spare_valid_ff;
   assign push     = in_valid && in_ready;

   always_comb begin
      main_valid_in  = main_valid_ff;
      main_data_in   = main_data_ff;
      main_flag_in   = main_flag_ff;
      spare_valid_in = spare_valid_ff;
      spare_data_in  = spare_data_ff;
      spare_flag_in  = spare_flag_ff;
      if (!main_valid_ff || out_ready) begin
         if (spare_valid_ff) begin
            main_valid_in  = 1'b1;
            main_data_in   = spare_data_ff;
            main_flag_in   = spare_flag_ff;
            spare_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = in_data;
            main_flag_in  = in_flag;
         end
      end else if (push) begin
         spare_valid_in = 1'b1;
         spare_data_in  = in_data;
         spare_flag_in  = in_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         main_valid_ff  <= main_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff  <= main_data_in;
      main_flag_ff  <= main_flag_in;
      spare_data_ff <= spare_data_in;
      spare_flag_ff <= spare_flag_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign out_flag  = main_flag_ff;

endmodule
